/* hw/rtl/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and codes for the dirty rectangle tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int COORD_BITS      = 12;
	localparam int MAX_ENTRIES_DEF = 8;
	localparam int CFG_IDX_W       = 1;

	localparam logic [COORD_BITS-1:0] WIDTH_RST  = 12'd320;
	localparam logic [COORD_BITS-1:0] HEIGHT_RST = 12'd240;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	// input modes
	localparam logic [1:0] MODE_MARK  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_FULL  = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_APPENDED  = 3'd0;
	localparam logic [2:0] STAT_MERGED    = 3'd1;
	localparam logic [2:0] STAT_COVERED   = 3'd2;
	localparam logic [2:0] STAT_INVALID   = 3'd3;
	localparam logic [2:0] STAT_COLLAPSED = 3'd4;
	localparam logic [2:0] STAT_DONE      = 3'd5;

	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
	} rect_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLIP,
		S_SCAN,
		S_FIN
	} state_t;

endpackage

/* hw/rtl/drt_cell.sv */
// ----------------------------------------------------------------------------
// drt_cell
// One slot of the rectangle ring: takes its neighbor's entry on a shift,
// or a direct value on a load.
// ----------------------------------------------------------------------------
module drt_cell (
	input  logic               clk,
	input  drt_pkg::cell_ctrl_t ctrl,
	input  drt_pkg::rect_t     load_val,
	input  drt_pkg::rect_t     d_in,
	output drt_pkg::rect_t     q
);
	import drt_pkg::*;

	rect_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= load_val;
		end else if (ctrl.shift) begin
			entry_q <= d_in;
		end
	end

	assign q = entry_q;

endmodule

/* hw/rtl/dirty_rectangle_tracker_unit.sv */
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker_unit
// Dirty rectangle list with clip, replace, merge, append and collapse.
// ----------------------------------------------------------------------------
// One item at a time. Mark and read pass from acceptance to result through
// clip, one rotation of the entry ring past the compare unit at its head (one
// entry per cycle), then presenting the result. Clear, full-screen marks and
// marks that clip to empty or hit a full-screen list skip the rotation.
// The next item is taken as soon as the result is in the output register.
// screen_width and screen_height must be written through the cfg port only
// while idle; the block itself does not enforce this.
module dirty_rectangle_tracker_unit #(
	parameter int MAX_ENTRIES = drt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic signed [12:0]                rect_x0,
	input  logic signed [12:0]                rect_y0,
	input  logic signed [12:0]                rect_x1,
	input  logic signed [12:0]                rect_y1,
	input  logic [2:0]                        read_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [3:0]                        entry_count,
	output logic                              full_dirty,
	output logic                              entry_valid,
	output logic [drt_pkg::COORD_BITS-1:0]    entry_x0,
	output logic [drt_pkg::COORD_BITS-1:0]    entry_y0,
	output logic [drt_pkg::COORD_BITS-1:0]    entry_x1,
	output logic [drt_pkg::COORD_BITS-1:0]    entry_y1,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drt_pkg::COORD_BITS-1:0]    cfg_data
);
	import drt_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;
	localparam int CW    = COORD_BITS;

	function automatic logic holds(input rect_t a, input rect_t b);
		holds = (a.x0 <= b.x0) && (a.y0 <= b.y0) && (a.x1 >= b.x1) && (a.y1 >= b.y1);
	endfunction

	function automatic logic overlaps(input rect_t a, input rect_t b);
		overlaps = (a.x0 < b.x1) && (a.x1 > b.x0) && (a.y0 < b.y1) && (a.y1 > b.y0);
	endfunction

	state_t state_q, state_d;

	logic [CW-1:0]    width_q, height_q;
	logic [CNT_W-1:0] count_q, k_q;
	logic             hit_q;
	logic [2:0]       stat_q;
	logic [1:0]       mode_q;
	logic signed [12:0] x0_q, y0_q, x1_q, y1_q;
	logic [2:0]       idx_q;
	rect_t            r_q, rd_q;
	logic             rd_valid_q;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [3:0]       entry_count_q;
	logic             full_dirty_q, entry_valid_q;
	rect_t            entry_q;

	rect_t      cell_q   [MAX_ENTRIES];
	cell_ctrl_t cell_ctl [MAX_ENTRIES];
	rect_t      head, tail_in, full_box, uni, clip_r;

	logic accept, out_load, clip_empty, full_now;
	logic active, h_new, h_old, ovl, append_now, collapse_now, last_step, read_hit;
	logic signed [13:0] x0c, y0c, x1c, y1c;

	// ---------------- entry ring ----------------
	assign head     = cell_q[0];
	assign full_box = '{x0: '0, y0: '0, x1: width_q, y1: height_q};

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		rect_t d_in;
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign d_in = tail_in;
		end else begin : g_mid
			assign d_in = cell_q[i+1];
		end
		assign cell_ctl[i].shift = (state_q == S_SCAN);
		if (i == 0) begin : g_head
			assign cell_ctl[i].load = (state_q == S_CLIP && mode_q == MODE_FULL) ||
				(state_q == S_SCAN && collapse_now);
		end else begin : g_rest
			assign cell_ctl[i].load = 1'b0;
		end
		drt_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctl[i]),
			.load_val (full_box),
			.d_in     (d_in),
			.q        (cell_q[i])
		);
	end

	// ---------------- clip ----------------
	always_comb begin
		x0c = x0_q[12] ? 14'sd0 : {1'b0, x0_q};
		y0c = y0_q[12] ? 14'sd0 : {1'b0, y0_q};
		x1c = ($signed({x1_q[12], x1_q}) > $signed({2'b00, width_q}))
			? $signed({2'b00, width_q}) : $signed({x1_q[12], x1_q});
		y1c = ($signed({y1_q[12], y1_q}) > $signed({2'b00, height_q}))
			? $signed({2'b00, height_q}) : $signed({y1_q[12], y1_q});
		clip_empty = !(x0c < x1c) || !(y0c < y1c);
		clip_r.x0 = x0c[CW-1:0];
		clip_r.y0 = y0c[CW-1:0];
		clip_r.x1 = x1c[CW-1:0];
		clip_r.y1 = y1c[CW-1:0];
	end

	assign full_now = (count_q == CNT_W'(1)) && (head == full_box);

	// ---------------- compare at the ring head ----------------
	always_comb begin
		h_new  = holds(r_q, head);
		h_old  = holds(head, r_q);
		ovl    = overlaps(r_q, head);
		uni.x0 = (r_q.x0 < head.x0) ? r_q.x0 : head.x0;
		uni.y0 = (r_q.y0 < head.y0) ? r_q.y0 : head.y0;
		uni.x1 = (r_q.x1 > head.x1) ? r_q.x1 : head.x1;
		uni.y1 = (r_q.y1 > head.y1) ? r_q.y1 : head.y1;

		active     = (mode_q == MODE_MARK) && !hit_q && (k_q < count_q);
		append_now = (mode_q == MODE_MARK) && !hit_q && (k_q == count_q);
		last_step  = (k_q == CNT_W'(MAX_ENTRIES - 1));
		// list full and nothing matched on the final entry
		collapse_now = (mode_q == MODE_MARK) && last_step && !hit_q && !append_now &&
			!(active && (h_new || h_old || ovl));
		read_hit = (mode_q == MODE_READ) &&
			(CMP_W'(idx_q) == CMP_W'(k_q)) && (CMP_W'(idx_q) < CMP_W'(count_q));

		tail_in = head;
		if (active && h_new) begin
			tail_in = r_q;
		end else if (active && h_old) begin
			tail_in = head;
		end else if (active && ovl) begin
			tail_in = uni;
		end else if (append_now) begin
			tail_in = r_q;
		end
	end

	// ---------------- control ----------------
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CLIP;
			end
			S_CLIP: begin
				if ((mode_q == MODE_MARK && !clip_empty && !full_now) || mode_q == MODE_READ)
					state_d = S_SCAN;
				else
					state_d = S_FIN;
			end
			S_SCAN: begin
				if (last_step) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			count_q     <= '0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			stat_q      <= STAT_DONE;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  width_q  <= cfg_data;
					REG_SCREEN_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == S_CLIP) begin
				k_q        <= '0;
				hit_q      <= 1'b0;
				rd_valid_q <= 1'b0;
				stat_q     <= STAT_DONE;
				case (mode_q)
					MODE_MARK: begin
						if (clip_empty)     stat_q <= STAT_INVALID;
						else if (full_now)  stat_q <= STAT_COVERED;
					end
					MODE_CLEAR: count_q <= '0;
					MODE_FULL:  count_q <= CNT_W'(1);
					default: ;
				endcase
			end

			if (state_q == S_SCAN) begin
				k_q <= k_q + CNT_W'(1);
				if (active && (h_new || h_old || ovl)) begin
					hit_q  <= 1'b1;
					stat_q <= (h_old && !h_new) ? STAT_COVERED : STAT_MERGED;
				end else if (append_now) begin
					hit_q   <= 1'b1;
					stat_q  <= STAT_APPENDED;
					count_q <= count_q + CNT_W'(1);
				end else if (collapse_now) begin
					stat_q  <= STAT_COLLAPSED;
					count_q <= CNT_W'(1);
				end
				if (read_hit) rd_valid_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			x0_q   <= rect_x0;
			y0_q   <= rect_y0;
			x1_q   <= rect_x1;
			y1_q   <= rect_y1;
			idx_q  <= read_index;
		end
		if (state_q == S_CLIP) begin
			r_q  <= clip_r;
			rd_q <= '0;
		end
		if (state_q == S_SCAN && read_hit) begin
			rd_q <= head;
		end
		if (out_load) begin
			status_q      <= stat_q;
			entry_count_q <= 4'(count_q);
			full_dirty_q  <= full_now;
			entry_valid_q <= rd_valid_q;
			entry_q       <= rd_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign full_dirty  = full_dirty_q;
	assign entry_valid = entry_valid_q;
	assign entry_x0    = entry_q.x0;
	assign entry_y0    = entry_q.y0;
	assign entry_x1    = entry_q.x1;
	assign entry_y1    = entry_q.y1;

endmodule

/* dv/dirty_rectangle_tracker_checker.sv */
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker_checker
// Watches the command, result and register channels of the dirty rectangle
// tracker, keeps its own copy of the rectangle list and the screen size, and
// compares every result transaction against the predicted one in order.
// ----------------------------------------------------------------------------
module dirty_rectangle_tracker_checker #(
	parameter int MAX_ENTRIES = drt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     mode,
	input  logic signed [12:0]             rect_x0,
	input  logic signed [12:0]             rect_y0,
	input  logic signed [12:0]             rect_x1,
	input  logic signed [12:0]             rect_y1,
	input  logic [2:0]                     read_index,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [2:0]                     status,
	input  logic [3:0]                     entry_count,
	input  logic                           full_dirty,
	input  logic                           entry_valid,
	input  logic [drt_pkg::COORD_BITS-1:0] entry_x0,
	input  logic [drt_pkg::COORD_BITS-1:0] entry_y0,
	input  logic [drt_pkg::COORD_BITS-1:0] entry_x1,
	input  logic [drt_pkg::COORD_BITS-1:0] entry_y1,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [drt_pkg::COORD_BITS-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending
);
	import drt_pkg::*;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] count;
		logic       full;
		logic       valid;
		rect_t      entry;
	} tracker_result_t;

	rect_t           dirty_list [MAX_ENTRIES];
	int unsigned     dirty_cnt;
	logic [COORD_BITS-1:0] scr_w;
	logic [COORD_BITS-1:0] scr_h;
	tracker_result_t result_q [$];
	int              errs;

	function automatic logic encloses(rect_t a, rect_t b);
		return a.x0 <= b.x0 && a.y0 <= b.y0 && a.x1 >= b.x1 && a.y1 >= b.y1;
	endfunction

	function automatic logic intersects(rect_t a, rect_t b);
		return a.x0 < b.x1 && a.x1 > b.x0 && a.y0 < b.y1 && a.y1 > b.y0;
	endfunction

	// whole-screen test follows the current register values
	function automatic logic screen_covered();
		return dirty_cnt == 1 && dirty_list[0].x0 == 0 && dirty_list[0].y0 == 0 &&
			dirty_list[0].x1 == scr_w && dirty_list[0].y1 == scr_h;
	endfunction

	function automatic void cover_screen();
		dirty_cnt = 1;
		dirty_list[0] = '{x0: '0, y0: '0, x1: scr_w, y1: scr_h};
	endfunction

	function automatic logic [2:0] mark_rect(int x0, int y0, int x1, int y1);
		rect_t r;
		rect_t e;
		if (x0 < 0) x0 = 0;
		if (y0 < 0) y0 = 0;
		if (x1 > int'(scr_w)) x1 = int'(scr_w);
		if (y1 > int'(scr_h)) y1 = int'(scr_h);
		if (!(x0 < x1 && y0 < y1)) return STAT_INVALID;
		if (screen_covered()) return STAT_COVERED;
		r = '{x0: 12'(x0), y0: 12'(y0), x1: 12'(x1), y1: 12'(y1)};
		for (int i = 0; i < int'(dirty_cnt); i++) begin
			e = dirty_list[i];
			if (encloses(r, e)) begin
				dirty_list[i] = r;
				return STAT_MERGED;
			end
			if (encloses(e, r)) return STAT_COVERED;
			if (intersects(r, e)) begin
				dirty_list[i].x0 = (r.x0 < e.x0) ? r.x0 : e.x0;
				dirty_list[i].y0 = (r.y0 < e.y0) ? r.y0 : e.y0;
				dirty_list[i].x1 = (r.x1 > e.x1) ? r.x1 : e.x1;
				dirty_list[i].y1 = (r.y1 > e.y1) ? r.y1 : e.y1;
				return STAT_MERGED;
			end
		end
		if (dirty_cnt < MAX_ENTRIES) begin
			dirty_list[dirty_cnt] = r;
			dirty_cnt++;
			return STAT_APPENDED;
		end
		cover_screen();
		return STAT_COLLAPSED;
	endfunction

	function automatic tracker_result_t predict_result(logic [1:0] m, int x0, int y0,
			int x1, int y1, int unsigned idx);
		tracker_result_t res;
		res = '0;
		res.status = STAT_DONE;
		case (m)
			MODE_MARK: begin
				res.status = mark_rect(x0, y0, x1, y1);
			end
			MODE_CLEAR: begin
				dirty_cnt = 0;
			end
			MODE_FULL: begin
				cover_screen();
			end
			default: begin
				if (idx < dirty_cnt) begin
					res.valid = 1'b1;
					res.entry = dirty_list[idx];
				end
			end
		endcase
		res.count = 4'(dirty_cnt);
		res.full  = screen_covered();
		return res;
	endfunction

	function automatic int field_differs(string name, int unsigned want, int unsigned got);
		if (want == got) return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tracker_result_t want;
		int              bad;
		if (!arst_n) begin
			result_q.delete();
			dirty_cnt  = 0;
			scr_w      = WIDTH_RST;
			scr_h      = HEIGHT_RST;
			errs       = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCREEN_WIDTH) scr_w = cfg_data;
				else if (cfg_index == REG_SCREEN_HEIGHT) scr_h = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result transaction with no command outstanding");
					errs++;
				end else begin
					want = result_q.pop_front();
					bad  = field_differs("status", want.status, status);
					bad += field_differs("entry_count", want.count, entry_count);
					bad += field_differs("full_dirty", want.full, full_dirty);
					bad += field_differs("entry_valid", want.valid, entry_valid);
					bad += field_differs("entry_x0", want.entry.x0, entry_x0);
					bad += field_differs("entry_y0", want.entry.y0, entry_y0);
					bad += field_differs("entry_x1", want.entry.x1, entry_x1);
					bad += field_differs("entry_y1", want.entry.y1, entry_y1);
					if (bad != 0) errs++;
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(predict_result(mode, rect_x0, rect_y0, rect_x1, rect_y1,
					read_index));
			fail_count <= errs;
			pending    <= result_q.size();
		end
	end

endmodule

/* dv/dirty_rectangle_tracker_unit_test.sv */
// ----------------------------------------------------------------------------
// dirty_rectangle_tracker_unit_test
// Drives directed and random mark, clear, full-screen and read commands into
// the tracker across a range of screen sizes, with random bursts of idling on
// both channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module dirty_rectangle_tracker_unit_test;
	import drt_pkg::*;

	localparam int ENTRIES = MAX_ENTRIES_DEF;
	localparam int LATENCY = ENTRIES + 3;
	localparam int CYCLE_LIMIT = 600000;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode        = MODE_CLEAR;
	logic signed [12:0]    rect_x0     = '0;
	logic signed [12:0]    rect_y0     = '0;
	logic signed [12:0]    rect_x1     = '0;
	logic signed [12:0]    rect_y1     = '0;
	logic [2:0]            read_index  = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [2:0]            status;
	logic [3:0]            entry_count;
	logic                  full_dirty;
	logic                  entry_valid;
	logic [COORD_BITS-1:0] entry_x0;
	logic [COORD_BITS-1:0] entry_y0;
	logic [COORD_BITS-1:0] entry_x1;
	logic [COORD_BITS-1:0] entry_y1;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = REG_SCREEN_WIDTH;
	logic [COORD_BITS-1:0] cfg_data    = '0;

	int fail_count;
	int pending;
	int cycles     = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;
	logic wind_down = 1'b0;
	int stall_left = 0;
	int cur_w      = WIDTH_RST;
	int cur_h      = HEIGHT_RST;

	dirty_rectangle_tracker_unit #(.MAX_ENTRIES(ENTRIES)) u_dut (.*);

	dirty_rectangle_tracker_checker #(.MAX_ENTRIES(ENTRIES)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side back-pressure, in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left > 1);
		end else if (!wind_down && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(13, 1);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic push_item(logic [1:0] m, int x0, int y0, int x1, int y1, int idx);
		if (!wind_down && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		rect_x0    <= 13'(x0);
		rect_y0    <= 13'(y0);
		rect_x1    <= 13'(x1);
		rect_y1    <= 13'(y1);
		read_index <= 3'(idx);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic mark(int x0, int y0, int x1, int y1);
		push_item(MODE_MARK, x0, y0, x1, y1, 0);
	endtask

	task automatic read_back(int idx);
		push_item(MODE_READ, 0, 0, 0, 0, idx);
	endtask

	// every command returns a result, so an empty scoreboard means idle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_screen(int w, int h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data  <= 12'(w);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data  <= 12'(h);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_w = w;
		cur_h = h;
		@(posedge clk);
	endtask

	function automatic int noise13();
		logic signed [12:0] v;
		v = 13'($urandom);
		return v;
	endfunction

	task automatic random_item(int div);
		int pick;
		int shape;
		int sx;
		int sy;
		int x0;
		int y0;
		int x1;
		int y1;
		pick = $urandom_range(99);
		x0 = noise13();
		y0 = noise13();
		x1 = noise13();
		y1 = noise13();
		if (pick < 64) begin
			if ($urandom_range(99) >= 10 && cur_w >= 2 && cur_h >= 2) begin
				sx = (cur_w / div > 1) ? cur_w / div : 1;
				sy = (cur_h / div > 1) ? cur_h / div : 1;
				shape = $urandom_range(9);
				if (shape < 2) begin
					// big rectangle, tends to swallow or merge entries
					x0 = $urandom_range(cur_w / 2);
					y0 = $urandom_range(cur_h / 2);
					x1 = x0 + int'($urandom_range(cur_w, 1));
					y1 = y0 + int'($urandom_range(cur_h, 1));
				end else begin
					x0 = $urandom_range(cur_w - 1);
					y0 = $urandom_range(cur_h - 1);
					x1 = x0 + int'($urandom_range(sx, 1));
					y1 = y0 + int'($urandom_range(sy, 1));
					if (shape < 4) begin
						x0 -= int'($urandom_range(sx));
						y0 -= int'($urandom_range(sy));
					end
				end
				if (x1 > 4095) x1 = 4095;
				if (y1 > 4095) y1 = 4095;
			end
			push_item(MODE_MARK, x0, y0, x1, y1, $urandom_range(7));
		end else if (pick < 94) begin
			push_item(MODE_READ, x0, y0, x1, y1, $urandom_range(7));
		end else if (pick < 97) begin
			push_item(MODE_CLEAR, x0, y0, x1, y1, $urandom_range(7));
		end else begin
			push_item(MODE_FULL, x0, y0, x1, y1, $urandom_range(7));
		end
	endtask

	task automatic run_phase(int w, int h, int n, int div, int gap, int stall);
		drain();
		set_screen(w, h);
		gap_pct = gap;
		stall_pct <= stall;
		repeat (n) random_item(div);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 30;
		stall_pct <= 30;

		// directed, reset screen size 320x240
		read_back(0);
		mark(-4096, -4096, 4095, 4095);
		mark(5, 5, 6, 6);
		read_back(0);
		push_item(MODE_CLEAR, 0, 0, 0, 0, 0);
		mark(10, 10, 50, 50);
		mark(20, 20, 30, 30);
		mark(0, 0, 100, 100);
		mark(90, 90, 150, 150);
		mark(150, 0, 160, 10);
		mark(320, 0, 330, 10);
		mark(0, 240, 10, 250);
		mark(40, 40, 40, 60);
		mark(4095, 4095, -4096, -4096);
		read_back(1);
		read_back(7);
		for (int i = 0; i < 6; i++) mark(i * 30, 200, i * 30 + 10, 210);
		mark(300, 100, 310, 110);
		push_item(MODE_FULL, 0, 0, 0, 0, 0);
		// a new screen size ends the whole-screen state
		drain();
		set_screen(640, 480);
		mark(330, 250, 340, 260);
		read_back(1);

		run_phase(320, 240, 300, 8, 25, 25);
		run_phase(64, 48, 250, 4, 40, 10);
		run_phase(4095, 4095, 250, 16, 10, 40);
		run_phase(1, 1, 60, 1, 20, 20);
		run_phase(4095, 1, 120, 8, 20, 20);
		run_phase(1, 4095, 120, 8, 20, 20);
		run_phase(0, 0, 40, 1, 20, 20);
		run_phase($urandom_range(4095, 1), $urandom_range(4095, 1), 200, 6, 30, 30);
		run_phase($urandom_range(600, 2), $urandom_range(600, 2), 200, 10, 15, 50);
		run_phase(320, 240, 200, 12, 0, 0);
		drain();
		wind_down <= 1'b1;
		run_phase($urandom_range(1024, 16), $urandom_range(1024, 16), 300, 8, 0, 0);

		drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
